// ===== src/swik_pkg.sv =====
// ----------------------------------------------------------------------------
// swik_pkg
// Shared types, constants and the arctangent table of the swerve inverse
// kinematics core.
// ----------------------------------------------------------------------------
package swik_pkg;

  localparam int FIELD_W     = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_BASE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRACK_WIDTH = 2'd1;

  localparam logic [FIELD_W-1:0] WHEEL_BASE_RST  = 16'd5888;
  localparam logic [FIELD_W-1:0] TRACK_WIDTH_RST = 16'd5888;

  localparam int CORDIC_STAGES_DEF = 16;

  // front end deadbands
  localparam int                 IN_SQ_W        = 31;
  localparam logic [31:0]        TRANS_DB_LIMIT = 32'd41943;
  localparam logic signed [15:0] ROT_DB_HI      = 16'sd204;
  localparam logic signed [15:0] ROT_DB_LO      = -16'sd204;

  localparam int QUEUE_DEPTH = 2;

  // diagonal square root
  localparam int DIAG_W     = 25;
  localparam int DIAG_V_W   = 50;
  localparam int DIAG_STEPS = 25;

  // datapath widths
  localparam int MIX_NUM_W = 41;
  localparam int MIX_Q_W   = 16;
  localparam int WV_W      = 18;
  localparam int SQP_W     = 33;
  localparam int SQ_W      = 34;
  localparam int RAD_W     = 40;
  localparam int MAG_W     = 20;
  localparam int NRM_Q_W   = 16;
  localparam int CORDIC_W  = 34;
  localparam int ANGLE_W   = 32;

  typedef enum logic [1:0] {
    DIAG_IDLE,
    DIAG_LOAD,
    DIAG_ITER
  } diag_state_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] rot;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] wheel_base;
    logic [FIELD_W-1:0] track_width;
    logic [DIAG_W-1:0]  diag;
  } cfg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] fr_speed;
    logic [FIELD_W-1:0] fr_angle;
    logic [FIELD_W-1:0] fl_speed;
    logic [FIELD_W-1:0] fl_angle;
    logic [FIELD_W-1:0] bl_speed;
    logic [FIELD_W-1:0] bl_angle;
    logic [FIELD_W-1:0] br_speed;
    logic [FIELD_W-1:0] br_angle;
  } result_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
    logic [ANGLE_W-1:0] t;
    unique case (idx)
      5'd0:  t = 32'h2000_0000;
      5'd1:  t = 32'h12E4_051E;
      5'd2:  t = 32'h09FB_385B;
      5'd3:  t = 32'h0511_11D4;
      5'd4:  t = 32'h028B_0D43;
      5'd5:  t = 32'h0145_D7E1;
      5'd6:  t = 32'h00A2_F61E;
      5'd7:  t = 32'h0051_7C55;
      5'd8:  t = 32'h0028_BE53;
      5'd9:  t = 32'h0014_5F2F;
      5'd10: t = 32'h000A_2F98;
      5'd11: t = 32'h0005_17CC;
      5'd12: t = 32'h0002_8BE6;
      5'd13: t = 32'h0001_45F3;
      5'd14: t = 32'h0000_A2FA;
      5'd15: t = 32'h0000_517D;
      5'd16: t = 32'h0000_28BE;
      5'd17: t = 32'h0000_145F;
      5'd18: t = 32'h0000_0A30;
      5'd19: t = 32'h0000_0518;
      5'd20: t = 32'h0000_028C;
      5'd21: t = 32'h0000_0146;
      5'd22: t = 32'h0000_00A3;
      5'd23: t = 32'h0000_0051;
      5'd24: t = 32'h0000_0029;
      5'd25: t = 32'h0000_0014;
      5'd26: t = 32'h0000_000A;
      5'd27: t = 32'h0000_0005;
      5'd28: t = 32'h0000_0003;
      5'd29: t = 32'h0000_0001;
      5'd30: t = 32'h0000_0001;
      5'd31: t = 32'h0000_0000;
    endcase
    return t;
  endfunction

endpackage

// ===== src/swik_diag.sv =====
// ----------------------------------------------------------------------------
// swik_diag
// Geometry registers and a bit-serial square root that derives the scaled
// wheel diagonal after reset and after every register write.
// ----------------------------------------------------------------------------
module swik_diag (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [swik_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [swik_pkg::FIELD_W-1:0]          cfg_data,
  output swik_pkg::cfg_t                        cfg,
  output logic                                  busy
);

  localparam int VW     = swik_pkg::DIAG_V_W;
  localparam int STEP_W = $clog2(swik_pkg::DIAG_STEPS);

  swik_pkg::diag_state_t state_r, state_nxt;

  logic [swik_pkg::FIELD_W-1:0] wb_r, tw_r;
  logic [VW-1:0]                v_r, v_nxt;
  logic [VW-1:0]                root_r, root_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic [swik_pkg::DIAG_W-1:0]  diag_r, diag_nxt;
  logic [VW-1:0]                bitv, trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= swik_pkg::WHEEL_BASE_RST;
      tw_r <= swik_pkg::TRACK_WIDTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == swik_pkg::REG_WHEEL_BASE) begin
        wb_r <= cfg_data;
      end
      if (cfg_index == swik_pkg::REG_TRACK_WIDTH) begin
        tw_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swik_pkg::DIAG_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    root_r <= root_nxt;
    step_r <= step_nxt;
    diag_r <= diag_nxt;
  end

  assign bitv  = VW'(1) << {step_r, 1'b0};
  assign trial = root_r + bitv;

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    root_nxt  = root_r;
    step_nxt  = step_r;
    diag_nxt  = diag_r;
    unique case (state_r)
      swik_pkg::DIAG_IDLE: begin
      end
      swik_pkg::DIAG_LOAD: begin
        v_nxt     = (VW'(32'(wb_r) * 32'(wb_r)) + VW'(32'(tw_r) * 32'(tw_r))) << 16;
        root_nxt  = '0;
        step_nxt  = STEP_W'(swik_pkg::DIAG_STEPS - 1);
        state_nxt = swik_pkg::DIAG_ITER;
      end
      swik_pkg::DIAG_ITER: begin
        if (v_r >= trial) begin
          v_nxt    = v_r - trial;
          root_nxt = (root_r >> 1) + bitv;
        end else begin
          root_nxt = root_r >> 1;
        end
        if (step_r == '0) begin
          diag_nxt  = root_nxt[swik_pkg::DIAG_W-1:0];
          state_nxt = swik_pkg::DIAG_IDLE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      default: begin
        state_nxt = swik_pkg::DIAG_LOAD;
      end
    endcase
    if (cfg_we) begin
      state_nxt = swik_pkg::DIAG_LOAD;
    end
  end

  assign busy             = (state_r != swik_pkg::DIAG_IDLE);
  assign cfg.wheel_base   = wb_r;
  assign cfg.track_width  = tw_r;
  assign cfg.diag         = diag_r;

  a_iter_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swik_pkg::DIAG_ITER && step_r == '0 && !cfg_we)
      |=> (state_r == swik_pkg::DIAG_IDLE))
    else $error("diagonal root did not finish after its last step");

endmodule

// ===== src/swik_front.sv =====
// ----------------------------------------------------------------------------
// swik_front
// Command intake: takes a transfer, applies the translation and rotation
// deadbands and hands the cleaned command to the queue.
// ----------------------------------------------------------------------------
module swik_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [swik_pkg::FIELD_W-1:0]  x_speed,
  input  logic signed [swik_pkg::FIELD_W-1:0]  y_speed,
  input  logic signed [swik_pkg::FIELD_W-1:0]  rot_speed,
  output logic                                 push,
  output swik_pkg::cmd_t                       push_cmd
);

  logic                          acc;
  logic signed [31:0]            xsq_full, ysq_full;
  logic                          v0_r, v1_r;
  swik_pkg::cmd_t                c0_r, c1_r;
  logic [swik_pkg::IN_SQ_W-1:0]  xsq_r, ysq_r;
  logic [31:0]                   sum;
  logic                          trans_small, rot_small;

  assign acc      = start && !busy;
  assign xsq_full = 32'(x_speed) * 32'(x_speed);
  assign ysq_full = 32'(y_speed) * 32'(y_speed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= acc;
      v1_r <= v0_r;
    end
  end

  // capture the command and its squares
  always_ff @(posedge clk) begin
    c0_r.x   <= x_speed;
    c0_r.y   <= y_speed;
    c0_r.rot <= rot_speed;
    xsq_r    <= xsq_full[swik_pkg::IN_SQ_W-1:0];
    ysq_r    <= ysq_full[swik_pkg::IN_SQ_W-1:0];
  end

  assign sum         = 32'(xsq_r) + 32'(ysq_r);
  assign trans_small = (sum <= swik_pkg::TRANS_DB_LIMIT);
  assign rot_small   = (c0_r.rot <= swik_pkg::ROT_DB_HI) && (c0_r.rot >= swik_pkg::ROT_DB_LO);

  // drop small commands to zero
  always_ff @(posedge clk) begin
    c1_r.x   <= trans_small ? '0 : c0_r.x;
    c1_r.y   <= trans_small ? '0 : c0_r.y;
    c1_r.rot <= rot_small ? '0 : c0_r.rot;
  end

  assign push     = v1_r;
  assign push_cmd = c1_r;

endmodule

// ===== src/swik_queue.sv =====
// ----------------------------------------------------------------------------
// swik_queue
// Short command queue between intake and the kinematics pipeline.
// ----------------------------------------------------------------------------
module swik_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  swik_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  output swik_pkg::cmd_t  pop_cmd
);

  localparam int DEPTH = swik_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  swik_pkg::cmd_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               pop;

  // the pipeline behind never stalls: drain one entry every cycle
  assign pop       = (count_r != '0);
  assign pop_valid = pop;
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)))
    else $error("command queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) + CNT_W'($past(push)) - CNT_W'($past(pop))))
    else $error("command queue count out of step with transfers");

endmodule

// ===== src/swik_back.sv =====
// ----------------------------------------------------------------------------
// swik_back
// Kinematics pipeline: rotation mixing by restoring division, per-wheel
// magnitude square roots, normalization divides and vectoring CORDICs.
// ----------------------------------------------------------------------------
module swik_back #(
  parameter int CORDIC_STAGES = swik_pkg::CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  swik_pkg::cmd_t   in_cmd,
  input  swik_pkg::cfg_t   cfg,
  output logic             out_valid,
  output swik_pkg::result_t out_res
);

  localparam int FW       = swik_pkg::FIELD_W;
  localparam int QW       = swik_pkg::MIX_Q_W;
  localparam int NW       = swik_pkg::MIX_NUM_W;
  localparam int WV       = swik_pkg::WV_W;
  localparam int RW       = swik_pkg::RAD_W;
  localparam int MW       = swik_pkg::MAG_W;
  localparam int SQRT_N   = swik_pkg::MAG_W;
  localparam int DW       = swik_pkg::NRM_Q_W;
  localparam int DNW      = MW + DW;
  localparam int CW       = swik_pkg::CORDIC_W;
  localparam int AW       = swik_pkg::ANGLE_W;
  localparam int NWHL     = 4;
  localparam int MAG_PATH = 2 + SQRT_N + 1 + DW;
  localparam int ANG_PATH = 2 + CORDIC_STAGES;
  localparam int ANG_DLY  = MAG_PATH - ANG_PATH;
  localparam int LAT      = 1 + QW + 1 + MAG_PATH + 1;

  // ---------------------------------------------------------------- valid line
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // ------------------------------------------------------ mixed term numerators
  logic [FW-1:0]        rot_mag;
  logic [NW-1:0]        remb_r [QW+1];
  logic [NW-1:0]        remt_r [QW+1];
  logic [QW-1:0]        qb_r   [QW+1];
  logic [QW-1:0]        qt_r   [QW+1];
  logic signed [FW-1:0] xd_r   [QW+1];
  logic signed [FW-1:0] yd_r   [QW+1];
  logic                 neg_r  [QW+1];

  assign rot_mag = in_cmd.rot[FW-1] ? FW'(-in_cmd.rot) : in_cmd.rot;

  always_ff @(posedge clk) begin
    remb_r[0] <= NW'({32'(rot_mag) * 32'(cfg.wheel_base), 8'd0}) + NW'(cfg.diag >> 1);
    remt_r[0] <= NW'({32'(rot_mag) * 32'(cfg.track_width), 8'd0}) + NW'(cfg.diag >> 1);
    qb_r[0]   <= '0;
    qt_r[0]   <= '0;
    xd_r[0]   <= in_cmd.x;
    yd_r[0]   <= in_cmd.y;
    neg_r[0]  <= in_cmd.rot[FW-1];
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QW; j++) begin : g_mixdiv
    localparam int SH = QW - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(cfg.diag) << SH;
    always_ff @(posedge clk) begin
      if (remb_r[j-1] >= dsh) begin
        remb_r[j] <= remb_r[j-1] - dsh;
        qb_r[j]   <= qb_r[j-1] | (QW'(1) << SH);
      end else begin
        remb_r[j] <= remb_r[j-1];
        qb_r[j]   <= qb_r[j-1];
      end
      if (remt_r[j-1] >= dsh) begin
        remt_r[j] <= remt_r[j-1] - dsh;
        qt_r[j]   <= qt_r[j-1] | (QW'(1) << SH);
      end else begin
        remt_r[j] <= remt_r[j-1];
        qt_r[j]   <= qt_r[j-1];
      end
      xd_r[j]  <= xd_r[j-1];
      yd_r[j]  <= yd_r[j-1];
      neg_r[j] <= neg_r[j-1];
    end
  end

  // ------------------------------------------------------------- wheel vectors
  logic signed [QW:0]   rb, rt;
  logic signed [WV-1:0] va, vb, vc, vd;
  logic signed [WV-1:0] pw_r [NWHL];
  logic signed [WV-1:0] qw_r [NWHL];

  // both spacings zero leaves no rotation term
  assign rb = (cfg.diag == '0) ? '0 :
              (neg_r[QW] ? -$signed({1'b0, qb_r[QW]}) : $signed({1'b0, qb_r[QW]}));
  assign rt = (cfg.diag == '0) ? '0 :
              (neg_r[QW] ? -$signed({1'b0, qt_r[QW]}) : $signed({1'b0, qt_r[QW]}));
  assign va = WV'(xd_r[QW]) - WV'(rb);
  assign vb = WV'(xd_r[QW]) + WV'(rb);
  assign vc = WV'(yd_r[QW]) - WV'(rt);
  assign vd = WV'(yd_r[QW]) + WV'(rt);

  always_ff @(posedge clk) begin
    pw_r[0] <= vb; qw_r[0] <= vc;
    pw_r[1] <= vb; qw_r[1] <= vd;
    pw_r[2] <= va; qw_r[2] <= vd;
    pw_r[3] <= va; qw_r[3] <= vc;
  end

  // ------------------------------------------------------------ magnitude path
  logic [swik_pkg::SQP_W-1:0] psq_r [NWHL];
  logic [swik_pkg::SQP_W-1:0] qsq_r [NWHL];
  logic [RW-1:0]              sv_r   [SQRT_N+1][NWHL];
  logic [RW-1:0]              root_r [SQRT_N+1][NWHL];
  logic                       big_r  [SQRT_N+1][NWHL];
  logic [MW-1:0]              mag    [NWHL];

  for (genvar k = 0; k < NWHL; k++) begin : g_sq
    logic signed [35:0]         pp, qq;
    logic [swik_pkg::SQ_W-1:0]  sq;
    assign pp = 36'(pw_r[k]) * 36'(pw_r[k]);
    assign qq = 36'(qw_r[k]) * 36'(qw_r[k]);
    assign sq = swik_pkg::SQ_W'(psq_r[k]) + swik_pkg::SQ_W'(qsq_r[k]);
    always_ff @(posedge clk) begin
      psq_r[k]     <= pp[swik_pkg::SQP_W-1:0];
      qsq_r[k]     <= qq[swik_pkg::SQP_W-1:0];
      sv_r[0][k]   <= {sq, 6'd0};
      root_r[0][k] <= '0;
      big_r[0][k]  <= (sq > swik_pkg::SQ_W'(1 << 24));
    end
    for (genvar j = 1; j <= SQRT_N; j++) begin : g_root
      localparam int BSH = 2 * (SQRT_N - j);
      logic [RW:0] trial;
      assign trial = (RW+1)'(root_r[j-1][k]) + ((RW+1)'(1) << BSH);
      always_ff @(posedge clk) begin
        if ((RW+1)'(sv_r[j-1][k]) >= trial) begin
          sv_r[j][k]   <= sv_r[j-1][k] - trial[RW-1:0];
          root_r[j][k] <= (root_r[j-1][k] >> 1) + (RW'(1) << BSH);
        end else begin
          sv_r[j][k]   <= sv_r[j-1][k];
          root_r[j][k] <= root_r[j-1][k] >> 1;
        end
        big_r[j][k] <= big_r[j-1][k];
      end
    end
    assign mag[k] = root_r[SQRT_N][k][MW-1:0];
  end

  // largest magnitude and normalize decision
  logic [MW-1:0]  max01, max23, mmax;
  logic [DNW-1:0] nrem_r [DW+1][NWHL];
  logic [DW-1:0]  nq_r   [DW+1][NWHL];
  logic [MW-1:0]  mk_r   [DW+1][NWHL];
  logic [MW-1:0]  mdiv_r [DW+1];
  logic           norm_r [DW+1];

  assign max01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign max23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
  assign mmax  = (max01 > max23) ? max01 : max23;

  always_ff @(posedge clk) begin
    mdiv_r[0] <= mmax;
    norm_r[0] <= big_r[SQRT_N][0] || big_r[SQRT_N][1] ||
                 big_r[SQRT_N][2] || big_r[SQRT_N][3];
  end

  for (genvar k = 0; k < NWHL; k++) begin : g_norm
    always_ff @(posedge clk) begin
      nrem_r[0][k] <= DNW'(mag[k]) << 15;
      nq_r[0][k]   <= '0;
      mk_r[0][k]   <= mag[k];
    end
    for (genvar j = 1; j <= DW; j++) begin : g_ndiv
      localparam int SH = DW - j;
      logic [DNW-1:0] dsh;
      assign dsh = DNW'(mdiv_r[j-1]) << SH;
      always_ff @(posedge clk) begin
        if (nrem_r[j-1][k] >= dsh) begin
          nrem_r[j][k] <= nrem_r[j-1][k] - dsh;
          nq_r[j][k]   <= nq_r[j-1][k] | (DW'(1) << SH);
        end else begin
          nrem_r[j][k] <= nrem_r[j-1][k];
          nq_r[j][k]   <= nq_r[j-1][k];
        end
        mk_r[j][k] <= mk_r[j-1][k];
      end
    end
  end

  for (genvar j = 1; j <= DW; j++) begin : g_nctl
    always_ff @(posedge clk) begin
      mdiv_r[j] <= mdiv_r[j-1];
      norm_r[j] <= norm_r[j-1];
    end
  end

  // ---------------------------------------------------------------- angle path
  logic signed [CW-1:0] cx_r  [CORDIC_STAGES+1][NWHL];
  logic signed [CW-1:0] cy_r  [CORDIC_STAGES+1][NWHL];
  logic [AW-1:0]        cz_r  [CORDIC_STAGES+1][NWHL];
  logic                 cnz_r [CORDIC_STAGES+1][NWHL];
  logic [FW-1:0]        ang_r [ANG_DLY+1][NWHL];

  for (genvar k = 0; k < NWHL; k++) begin : g_ang
    logic signed [CW-1:0] xs, ys;
    logic [AW-1:0]        zf, ang, rnd;
    assign xs = CW'(pw_r[k]) <<< 12;
    assign ys = CW'(qw_r[k]) <<< 12;
    // pre-rotate by a half turn for a vector in the left half plane
    always_ff @(posedge clk) begin
      if (pw_r[k] < 0) begin
        cx_r[0][k] <= -xs;
        cy_r[0][k] <= -ys;
        cz_r[0][k] <= 32'h8000_0000;
      end else begin
        cx_r[0][k] <= xs;
        cy_r[0][k] <= ys;
        cz_r[0][k] <= '0;
      end
      cnz_r[0][k] <= (pw_r[k] == '0) && (qw_r[k] == '0);
    end
    for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_rot
      localparam int SH = i - 1;
      logic signed [CW-1:0] dx, dy;
      logic [AW-1:0]        t;
      assign dx = cx_r[i-1][k] >>> SH;
      assign dy = cy_r[i-1][k] >>> SH;
      assign t  = swik_pkg::atan_turn(5'(SH));
      always_ff @(posedge clk) begin
        if (cy_r[i-1][k] < 0) begin
          cx_r[i][k] <= cx_r[i-1][k] - dy;
          cy_r[i][k] <= cy_r[i-1][k] + dx;
          cz_r[i][k] <= cz_r[i-1][k] - t;
        end else begin
          cx_r[i][k] <= cx_r[i-1][k] + dy;
          cy_r[i][k] <= cy_r[i-1][k] - dx;
          cz_r[i][k] <= cz_r[i-1][k] + t;
        end
        cnz_r[i][k] <= cnz_r[i-1][k];
      end
    end
    // steering angle is a quarter turn minus the vector angle, rounded half up
    assign zf  = cnz_r[CORDIC_STAGES][k] ? '0 : cz_r[CORDIC_STAGES][k];
    assign ang = 32'h4000_0000 - zf;
    assign rnd = ang + 32'h0000_8000;
    always_ff @(posedge clk) begin
      ang_r[0][k] <= rnd[AW-1:AW-FW];
    end
    for (genvar d = 1; d <= ANG_DLY; d++) begin : g_dly
      always_ff @(posedge clk) begin
        ang_r[d][k] <= ang_r[d-1][k];
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic [FW-1:0] spd_r  [NWHL];
  logic [FW-1:0] angs_r [NWHL];

  for (genvar k = 0; k < NWHL; k++) begin : g_out
    logic [MW-1:0] s;
    logic [FW-1:0] sat;
    assign s   = norm_r[DW] ? MW'(nq_r[DW][k]) : mk_r[DW][k];
    assign sat = (s > MW'(32767)) ? FW'(32767) : FW'(s);
    always_ff @(posedge clk) begin
      spd_r[k]  <= (k == 1 || k == 2) ? FW'(-sat) : sat;
      angs_r[k] <= ang_r[ANG_DLY][k];
    end
  end

  assign out_res.fr_speed = spd_r[0];
  assign out_res.fr_angle = angs_r[0];
  assign out_res.fl_speed = spd_r[1];
  assign out_res.fl_angle = angs_r[1];
  assign out_res.bl_speed = spd_r[2];
  assign out_res.bl_angle = angs_r[2];
  assign out_res.br_speed = spd_r[3];
  assign out_res.br_angle = angs_r[3];

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.fr_speed != 16'h8000) && (out_res.fl_speed != 16'h8000) &&
                  (out_res.bl_speed != 16'h8000) && (out_res.br_speed != 16'h8000))
    else $error("wheel speed outside saturation range");

endmodule

// ===== src/swerve_inverse_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_core
// Four-wheel swerve drive inverse kinematics: drive command in, speed and
// steering angle for each wheel out.
// ----------------------------------------------------------------------------
// A command transfer happens on a rising edge with start high and busy low;
// a new command may follow on every cycle. Each command yields exactly one
// result, shown for one cycle with out_valid high; the transfer edge loads
// the first of two intake stages, then come one queue stage and a 58-stage
// datapath set by the 16-step rotation divider, the 20-step magnitude root
// and the 16-step normalize divider. The receiver cannot stall the block and
// results come in command order. busy is high after reset and after every
// register write while the wheel diagonal is recomputed one root bit per
// cycle; write registers only while no command is in flight.
module swerve_inverse_kinematics_core #(
  parameter int CORDIC_STAGES = swik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [swik_pkg::FIELD_W-1:0]  in_x_speed,
  input  logic signed [swik_pkg::FIELD_W-1:0]  in_y_speed,
  input  logic signed [swik_pkg::FIELD_W-1:0]  in_rot_speed,
  // result channel
  output logic                                 out_valid,
  output logic signed [swik_pkg::FIELD_W-1:0]  out_fr_speed,
  output logic [swik_pkg::FIELD_W-1:0]         out_fr_angle,
  output logic signed [swik_pkg::FIELD_W-1:0]  out_fl_speed,
  output logic [swik_pkg::FIELD_W-1:0]         out_fl_angle,
  output logic signed [swik_pkg::FIELD_W-1:0]  out_bl_speed,
  output logic [swik_pkg::FIELD_W-1:0]         out_bl_angle,
  output logic signed [swik_pkg::FIELD_W-1:0]  out_br_speed,
  output logic [swik_pkg::FIELD_W-1:0]         out_br_angle,
  // register writes
  input  logic                                 cfg_we,
  input  logic [swik_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [swik_pkg::FIELD_W-1:0]         cfg_data
);

  swik_pkg::cfg_t    cfg;
  swik_pkg::cmd_t    push_cmd, pop_cmd;
  swik_pkg::result_t res;
  logic              push, pop_valid;

  // geometry registers and diagonal root; busy while it runs
  swik_diag u_diag (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .busy      (busy)
  );

  // intake: capture the command and apply both deadbands
  swik_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .x_speed   (in_x_speed),
    .y_speed   (in_y_speed),
    .rot_speed (in_rot_speed),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decouple intake from the datapath
  swik_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  // mixing, magnitudes, normalization and steering angles
  swik_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pop_valid),
    .in_cmd    (pop_cmd),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_fr_speed = res.fr_speed;
  assign out_fr_angle = res.fr_angle;
  assign out_fl_speed = res.fl_speed;
  assign out_fl_angle = res.fl_angle;
  assign out_bl_speed = res.bl_speed;
  assign out_bl_angle = res.bl_angle;
  assign out_br_speed = res.br_speed;
  assign out_br_angle = res.br_angle;

endmodule

// ===== tb/sv/swerve_inverse_kinematics_core_tb.sv =====
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_core_tb
// Self-checking bench for the four-wheel swerve inverse kinematics core.
// Commands go in through the start/busy handshake. A bit-exact predictor
// runs on every accepted transfer. Its result is queued and compared field
// by field with each out_valid strobe. Register writes happen only while
// the core is drained. The register settings include the extremes and
// indexes that do not exist.
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics_core_tb;

  localparam int STAGES      = swik_pkg::CORDIC_STAGES_DEF;
  localparam int FW          = swik_pkg::FIELD_W;
  localparam int IW          = swik_pkg::CFG_INDEX_W;
  localparam int LATENCY     = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_RANDOM    = 1040;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_LUT [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [FW-1:0] in_x_speed = '0;
  logic signed [FW-1:0] in_y_speed = '0;
  logic signed [FW-1:0] in_rot_speed = '0;
  logic out_valid;
  logic signed [FW-1:0] out_fr_speed, out_fl_speed, out_bl_speed, out_br_speed;
  logic [FW-1:0] out_fr_angle, out_fl_angle, out_bl_angle, out_br_angle;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [FW-1:0] cfg_data = '0;

  // shadow of the spacing registers, updated on every write to their indexes
  logic [FW-1:0] wheel_base_sh;
  logic [FW-1:0] track_width_sh;

  swik_pkg::result_t wheel_cmd_q[$];   // predicted wheel outputs, oldest first
  int errors = 0;
  int n_cmds = 0;
  int n_checked = 0;
  int n_writes = 0;
  int cycles = 0;
  bit allow_idle = 1'b1;

  swerve_inverse_kinematics_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_speed(in_x_speed), .in_y_speed(in_y_speed), .in_rot_speed(in_rot_speed),
    .out_valid(out_valid),
    .out_fr_speed(out_fr_speed), .out_fr_angle(out_fr_angle),
    .out_fl_speed(out_fl_speed), .out_fl_angle(out_fl_angle),
    .out_bl_speed(out_bl_speed), .out_bl_angle(out_bl_angle),
    .out_br_speed(out_br_speed), .out_br_angle(out_br_angle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_sq(input longint p, input longint q);
    longint unsigned a;
    longint unsigned b;
    a = (p < 0) ? -p : p;
    b = (q < 0) ? -q : q;
    return a * a + b * b;
  endfunction

  // vectoring CORDIC; floor shifts are arithmetic shifts
  function automatic logic [31:0] wheel_heading(input longint px, input longint py);
    logic [31:0] z;
    longint dx;
    longint dy;
    z = '0;
    if (px == 0 && py == 0) return '0;
    px = px * 4096;
    py = py * 4096;
    if (px < 0) begin
      px = -px;
      py = -py;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = px >>> i;
      dy = py >>> i;
      if (py < 0) begin
        px = px - dy;
        py = py + dx;
        z = z - ATAN_LUT[i];
      end else begin
        px = px + dy;
        py = py - dx;
        z = z + ATAN_LUT[i];
      end
    end
    return z;
  endfunction

  function automatic longint rot_share(input longint rot, input longint unsigned spacing,
                                       input longint unsigned diag);
    longint unsigned num;
    if (diag == 0) return 0;
    num = ((rot < 0) ? -rot : rot) * spacing * 256;
    num = (num + diag / 2) / diag;
    return (rot < 0) ? -longint'(num) : longint'(num);
  endfunction

  function automatic swik_pkg::result_t wheel_targets(input logic signed [FW-1:0] xs,
                                                      input logic signed [FW-1:0] ys,
                                                      input logic signed [FW-1:0] rs);
    longint x, y, r, rb, rt;
    longint px[4];
    longint py[4];
    longint unsigned sq[4];
    longint unsigned m[4];
    longint unsigned sqmax, mmax, diag, s, wb, tw;
    logic [31:0] ang;
    logic [FW-1:0] spd[4];
    logic [FW-1:0] hdg[4];
    swik_pkg::result_t res;
    x = xs;
    y = ys;
    r = rs;
    wb = wheel_base_sh;
    tw = track_width_sh;
    sqmax = 0;
    mmax = 0;
    // translation and rotation deadbands
    if (mag_sq(x, y) <= (64'd1 << 24) / 400) begin
      x = 0;
      y = 0;
    end
    if (((r < 0) ? -r : r) <= 4096 / 20) r = 0;
    diag = int_sqrt((wb * wb + tw * tw) << 16);
    rb = rot_share(r, wb, diag);
    rt = rot_share(r, tw, diag);
    px[0] = x + rb; py[0] = y - rt;
    px[1] = x + rb; py[1] = y + rt;
    px[2] = x - rb; py[2] = y + rt;
    px[3] = x - rb; py[3] = y - rt;
    for (int k = 0; k < 4; k++) begin
      sq[k] = mag_sq(px[k], py[k]);
      m[k] = int_sqrt(sq[k] << 6);
      if (sq[k] > sqmax) sqmax = sq[k];
      if (m[k] > mmax) mmax = m[k];
    end
    for (int k = 0; k < 4; k++) begin
      s = m[k];
      if (sqmax > (64'd1 << 24) && mmax != 0) s = (s * 32768) / mmax;
      if (s > 32767) s = 32767;
      spd[k] = (k == 1 || k == 2) ? FW'(-longint'(s)) : FW'(s);
      ang = 32'h4000_0000 - wheel_heading(px[k], py[k]);
      ang = ang + 32'h8000;
      hdg[k] = ang[31:16];
    end
    res.fr_speed = spd[0]; res.fr_angle = hdg[0];
    res.fl_speed = spd[1]; res.fl_angle = hdg[1];
    res.bl_speed = spd[2]; res.bl_angle = hdg[2];
    res.br_speed = spd[3]; res.br_angle = hdg[3];
    return res;
  endfunction

  // ----------------------------------------------- transfer monitor and checker
  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch %s (result %0d)", msg, n_checked);
  endtask

  task automatic check_field(input string what, input logic [FW-1:0] got,
                             input logic [FW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h expected %h", what, got, want));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      wheel_base_sh  <= swik_pkg::WHEEL_BASE_RST;
      track_width_sh <= swik_pkg::TRACK_WIDTH_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == swik_pkg::REG_WHEEL_BASE) wheel_base_sh <= cfg_data;
        else if (cfg_index == swik_pkg::REG_TRACK_WIDTH) track_width_sh <= cfg_data;
      end
      // predict on the accepted command, using the registers before any
      // write in the same cycle (writes only happen while drained)
      if (start && !busy) begin
        wheel_cmd_q.push_back(wheel_targets(in_x_speed, in_y_speed, in_rot_speed));
        n_cmds++;
      end
      if (out_valid) begin
        swik_pkg::result_t want;
        if (wheel_cmd_q.size() == 0) begin
          report_mismatch("unexpected result with nothing outstanding");
        end else begin
          want = wheel_cmd_q.pop_front();
          check_field("fr_speed", out_fr_speed, want.fr_speed);
          check_field("fr_angle", out_fr_angle, want.fr_angle);
          check_field("fl_speed", out_fl_speed, want.fl_speed);
          check_field("fl_angle", out_fl_angle, want.fl_angle);
          check_field("bl_speed", out_bl_speed, want.bl_speed);
          check_field("bl_angle", out_bl_angle, want.bl_angle);
          check_field("br_speed", out_br_speed, want.br_speed);
          check_field("br_angle", out_br_angle, want.br_angle);
          n_checked++;
        end
      end
    end
  end

  // watchdog: drop out if the run hangs
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               wheel_cmd_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------- drive tasks
  // Call at a rising edge. Hold the command until the core takes it, then
  // maybe idle for a random burst. Start stays high between back-to-back
  // transfers.
  task automatic send_cmd(input logic [15:0] xs, input logic [15:0] ys, input logic [15:0] rs);
    int gap;
    in_x_speed   <= xs;
    in_y_speed   <= ys;
    in_rot_speed <= rs;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // lower start, wait for every outstanding result, then hold off for the
  // pipeline depth so nothing is in flight
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (wheel_cmd_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
  endtask

  function automatic logic [15:0] rand_field;
    case ($urandom_range(0, 4))
      0: rand_field = 16'($urandom);
      1: rand_field = 16'($urandom_range(0, 600) - 300);     // around the deadbands
      2: rand_field = 16'($urandom_range(0, 16384) - 8192);  // typical commands
      3: rand_field = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: rand_field = 16'($urandom_range(0, 8) - 4);
    endcase
  endfunction

  // ----------------------------------------------------------------- tests
  task automatic test_deadbands;
    send_cmd(16'd0, 16'd0, 16'd0);        // zero wheel vectors
    send_cmd(16'd204, 16'd0, 16'd0);      // on the translation edge
    send_cmd(16'd205, 16'd0, 16'd0);      // just past it
    send_cmd(16'd145, -16'd144, 16'd0);
    send_cmd(16'd0, 16'd0, 16'd204);      // rotation edge, both signs
    send_cmd(16'd0, 16'd0, 16'd205);
    send_cmd(16'd0, 16'd0, -16'd204);
    send_cmd(16'd0, 16'd0, -16'd205);
  endtask

  task automatic test_extremes;
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cmd(16'h8000, 16'h8000, 16'h8000);
    send_cmd(16'h8000, 16'h7FFF, 16'h0000);
    send_cmd(16'h7FFF, 16'h8000, 16'h8000);
    send_cmd(-16'd4096, 16'd0, 16'd0);    // negative first operand
    send_cmd(-16'd4096, -16'd1, 16'd0);
    send_cmd(16'd0, 16'd4096, 16'd0);
    send_cmd(16'd0, -16'd4096, 16'd0);
    send_cmd(16'd2048, 16'd2048, 16'd1024); // below the normalize threshold
    send_cmd(16'd4096, 16'd0, 16'd4096);    // normalized
    send_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic config_phase(input logic [15:0] wb, input logic [15:0] tw, input int n);
    write_reg(swik_pkg::REG_WHEEL_BASE, wb);
    write_reg(swik_pkg::REG_TRACK_WIDTH, tw);
    send_cmd(16'd0, 16'd0, 16'h7FFF);
    send_cmd(16'd4096, -16'd2048, 16'h8000);
    repeat (n) send_cmd(rand_field(), rand_field(), rand_field());
  endtask

  task automatic test_config_sweep;
    config_phase(16'd1, 16'd1, 20);
    config_phase(16'hFFFF, 16'hFFFF, 20);
    config_phase(16'd1, 16'hFFFF, 20);
    config_phase(16'hFFFF, 16'd1, 20);
    config_phase(16'd0, 16'd0, 20);     // zero diagonal
    config_phase(16'd0, 16'd256, 10);
    // writes to unused indexes must leave both spacings alone
    write_reg(IW'(2), 16'd77);
    write_reg(IW'(3), 16'hFFFF);
    repeat (20) send_cmd(rand_field(), rand_field(), rand_field());
  endtask

  task automatic test_random;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 260 == 0)
        config_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 0);
      send_cmd(rand_field(), rand_field(), rand_field());
    end
  endtask

  task automatic test_back_to_back;
    allow_idle = 1'b0;
    write_reg(swik_pkg::REG_WHEEL_BASE, swik_pkg::WHEEL_BASE_RST);
    write_reg(swik_pkg::REG_TRACK_WIDTH, swik_pkg::TRACK_WIDTH_RST);
    repeat (100) send_cmd(rand_field(), rand_field(), rand_field());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_deadbands();
    test_extremes();
    test_config_sweep();
    test_random();
    test_back_to_back();
    drain();
    $display("covered %0d commands, %0d results checked, %0d register writes", n_cmds,
             n_checked, n_writes);
    $display("deadband edges, saturation, normalize, zero diagonal, unused indexes");
    if (errors == 0 && wheel_cmd_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
